// ===== hw/rtl/lwaq_pkg.sv =====
// lwaq_pkg: shared widths, codes, reset values and control bundles of the
// weighted admission queue. No dependencies; used by every rtl file.
package lwaq_pkg;

   localparam int ID_W     = 4;
   localparam int ACT_W    = 2;
   localparam int CLK_W    = 32;
   localparam int WT_W     = 8;
   localparam int CAP_W    = 16;
   localparam int AVAIL_W  = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int DEFAULT_MAX_NODES = 16;

   localparam logic [ID_W-1:0]  OWN_ID_RESET     = '0;
   localparam logic [WT_W-1:0]  OWN_WEIGHT_RESET = 8'd1;
   localparam logic [CAP_W-1:0] CAPACITY_RESET   = 16'd255;

   typedef enum logic [ACT_W-1:0] {
      ACT_REMOTE_REQ = 2'd0,
      ACT_REMOTE_REL = 2'd1,
      ACT_LOCAL_REQ  = 2'd2,
      ACT_LOCAL_REL  = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OWN_ID     = 2'd0,
      CSR_OWN_WEIGHT = 2'd1,
      CSR_CAPACITY   = 2'd2,
      CSR_UNUSED     = 2'd3
   } csr_index_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture the incoming transaction
      logic update;     // advance the clock (all but a local release), write the table
      logic rd_own;     // read own entry, start the walk
      logic walk_step;  // read next table entry
      logic out_load;   // fill the response register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic walk_last;  // last entry is being read
      logic out_free;   // response register can take a new result
   } sts_type;

   function automatic logic [CLK_W-1:0] clock_inc(input logic [CLK_W-1:0] c);
      return (c == '1) ? c : c + 1'b1;
   endfunction

endpackage

// ===== hw/rtl/lwaq_ctrl.sv =====
// lwaq_ctrl: sequencer of the admission queue, one event at a time.
// Depends on lwaq_pkg for the command and status bundles.
module lwaq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lwaq_pkg::sts_type sts,
   output lwaq_pkg::cmd_type cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_UPDATE = 6'b000010,
      ST_OWN    = 6'b000100,
      ST_WALK   = 6'b001000,
      ST_DRAIN  = 6'b010000,
      ST_RESP   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_OWN;
         end
         ST_OWN: begin
            cmd.rd_own = 1'b1;
            state_in   = ST_WALK;
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (sts.walk_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/lwaq_dp.sv =====
// lwaq_dp: clock, request table, configuration registers, walk and response.
// Depends on lwaq_pkg; driven by lwaq_ctrl through cmd_type / sts_type.
module lwaq_dp #(
   parameter int MAX_NODES = lwaq_pkg::DEFAULT_MAX_NODES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lwaq_pkg::cmd_type                 cmd,
   output lwaq_pkg::sts_type                 sts,
   input  logic [lwaq_pkg::ACT_W-1:0]        req_action,
   input  logic [lwaq_pkg::ID_W-1:0]         req_node_id,
   input  logic [lwaq_pkg::CLK_W-1:0]        req_stamp,
   input  logic [lwaq_pkg::WT_W-1:0]         req_weight,
   input  logic                              csr_wr,
   input  logic [lwaq_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lwaq_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic [lwaq_pkg::CLK_W-1:0]        rsp_local_clock,
   output logic signed [lwaq_pkg::AVAIL_W-1:0] rsp_available,
   output logic                              rsp_may_enter,
   output logic                              rsp_own_pending,
   output logic                              rsp_send_reply,
   output logic                              rsp_broadcast
);

   localparam int IDX_W  = $clog2(MAX_NODES);
   localparam int CNT_W  = $clog2(MAX_NODES + 1);
   localparam int WORD_W = lwaq_pkg::CLK_W + lwaq_pkg::WT_W;

   // configuration
   logic [lwaq_pkg::ID_W-1:0]  own_id_ff;
   logic [lwaq_pkg::WT_W-1:0]  own_wt_ff;
   logic [lwaq_pkg::CAP_W-1:0] cap_ff;

   // captured transaction
   lwaq_pkg::action_type       act_ff;
   logic [lwaq_pkg::ID_W-1:0]  node_ff;
   logic [lwaq_pkg::CLK_W-1:0] stamp_ff;
   logic [lwaq_pkg::WT_W-1:0]  wt_ff;

   // protocol state
   logic [lwaq_pkg::CLK_W-1:0] clk_ff, clk_in;
   logic [MAX_NODES-1:0]       valid_ff, valid_in;
   logic [WORD_W-1:0]          mem [MAX_NODES];
   logic                       wr_en;
   logic [IDX_W-1:0]           wr_idx;
   logic [WORD_W-1:0]          wr_word;

   // walk
   logic [CNT_W-1:0]           cnt_ff;
   logic                       tag_vld_ff, tag_own_ff;
   logic [IDX_W-1:0]           tag_idx_ff;
   logic [lwaq_pkg::CLK_W-1:0] rd_stamp_ff;
   logic [lwaq_pkg::WT_W-1:0]  rd_weight_ff;
   logic [lwaq_pkg::CLK_W-1:0] own_stamp_ff;
   logic                       pending_ff;
   logic signed [lwaq_pkg::AVAIL_W-1:0] avail_ff, avail_in;
   logic [IDX_W-1:0]           rd_addr;
   logic                       ahead;

   logic [lwaq_pkg::CLK_W-1:0] clk_base, clk_next;
   logic [IDX_W-1:0]           own_idx, node_idx;
   logic                       own_ok, remote_ok;
   logic signed [lwaq_pkg::AVAIL_W-1:0] own_wt_ext;

   assign own_idx   = IDX_W'(own_id_ff);
   assign node_idx  = IDX_W'(node_ff);
   assign own_ok    = (32'(own_id_ff) < MAX_NODES);
   assign remote_ok = (32'(node_ff) < MAX_NODES) && (node_ff != own_id_ff);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff <= lwaq_pkg::OWN_ID_RESET;
         own_wt_ff <= lwaq_pkg::OWN_WEIGHT_RESET;
         cap_ff    <= lwaq_pkg::CAPACITY_RESET;
      end else if (csr_wr) begin
         case (lwaq_pkg::csr_index_type'(csr_index))
            lwaq_pkg::CSR_OWN_ID:     own_id_ff <= csr_data[lwaq_pkg::ID_W-1:0];
            lwaq_pkg::CSR_OWN_WEIGHT: own_wt_ff <= csr_data[lwaq_pkg::WT_W-1:0];
            lwaq_pkg::CSR_CAPACITY:   cap_ff    <= csr_data[lwaq_pkg::CAP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff   <= lwaq_pkg::action_type'(req_action);
         node_ff  <= req_node_id;
         stamp_ff <= req_stamp;
         wt_ff    <= req_weight;
      end
   end

   // clock and table update
   assign clk_base = ((act_ff == lwaq_pkg::ACT_REMOTE_REQ) && (stamp_ff > clk_ff))
                     ? stamp_ff : clk_ff;
   assign clk_next = lwaq_pkg::clock_inc(clk_base);

   always_comb begin
      clk_in   = clk_ff;
      valid_in = valid_ff;
      wr_en    = 1'b0;
      wr_idx   = node_idx;
      wr_word  = {stamp_ff, wt_ff};
      if (cmd.update) begin
         case (act_ff)
            lwaq_pkg::ACT_REMOTE_REQ: begin
               clk_in = clk_next;
               if (remote_ok) begin
                  valid_in[node_idx] = 1'b1;
                  wr_en              = 1'b1;
               end
            end
            lwaq_pkg::ACT_REMOTE_REL: begin
               clk_in = clk_next;
               if (remote_ok) begin
                  valid_in[node_idx] = 1'b0;
               end
            end
            lwaq_pkg::ACT_LOCAL_REQ: begin
               clk_in  = clk_next;
               wr_idx  = own_idx;
               wr_word = {clk_next, own_wt_ff};
               if (own_ok) begin
                  valid_in[own_idx] = 1'b1;
                  wr_en             = 1'b1;
               end
            end
            lwaq_pkg::ACT_LOCAL_REL: begin
               if (own_ok) begin
                  valid_in[own_idx] = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clk_ff   <= '0;
         valid_ff <= '0;
      end else begin
         clk_ff   <= clk_in;
         valid_ff <= valid_in;
      end
   end

   // table storage, registered read
   assign rd_addr = cmd.rd_own ? own_idx : cnt_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_word;
      end
      if (cmd.rd_own || cmd.walk_step) begin
         {rd_stamp_ff, rd_weight_ff} <= mem[rd_addr];
      end
   end

   // walk control
   assign sts.walk_last = (cnt_ff == CNT_W'(MAX_NODES - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         tag_vld_ff <= 1'b0;
         tag_own_ff <= 1'b0;
      end else begin
         tag_vld_ff <= cmd.rd_own || cmd.walk_step;
         tag_own_ff <= cmd.rd_own;
         if (cmd.rd_own) begin
            cnt_ff <= '0;
         end else if (cmd.walk_step) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_step) begin
         tag_idx_ff <= cnt_ff[IDX_W-1:0];
      end
   end

   // order test against own entry by (stamp, id)
   assign ahead = !pending_ff || (rd_stamp_ff < own_stamp_ff) ||
                  ((rd_stamp_ff == own_stamp_ff) && (tag_idx_ff < own_idx));

   always_comb begin
      avail_in = avail_ff;
      if (cmd.rd_own) begin
         avail_in = $signed(lwaq_pkg::AVAIL_W'(cap_ff));
      end else if (tag_vld_ff && !tag_own_ff && valid_ff[tag_idx_ff] &&
                   !(pending_ff && (tag_idx_ff == own_idx)) && ahead) begin
         avail_in = avail_ff - $signed(lwaq_pkg::AVAIL_W'(rd_weight_ff));
      end
   end

   always_ff @(posedge clock) begin
      avail_ff <= avail_in;
      if (cmd.rd_own) begin
         pending_ff <= own_ok && valid_ff[own_idx];
      end
      if (tag_vld_ff && tag_own_ff) begin
         own_stamp_ff <= rd_stamp_ff;
      end
   end

   // response register
   assign own_wt_ext   = $signed(lwaq_pkg::AVAIL_W'(own_wt_ff));
   assign sts.out_free = !rsp_valid || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_local_clock <= clk_ff;
         rsp_available   <= avail_ff;
         rsp_may_enter   <= pending_ff && (own_wt_ext <= avail_ff);
         rsp_own_pending <= pending_ff;
         rsp_send_reply  <= (act_ff == lwaq_pkg::ACT_REMOTE_REQ);
         rsp_broadcast   <= (act_ff == lwaq_pkg::ACT_LOCAL_REQ);
      end
   end

endmodule

// ===== hw/rtl/lamport_weighted_admission_queue.sv =====
// lamport_weighted_admission_queue: top level, controller plus datapath.
// Depends on lwaq_pkg, lwaq_ctrl and lwaq_dp.
//
// usage
//  - req_*: one event per transaction (remote request, remote release,
//    local request, local release) with sender id, stamp and weight
//  - rsp_*: one result per event: clock after the event, available
//    capacity ahead of the own entry, may_enter, own_pending, reply and
//    broadcast flags
//  - csr_*: register writes (own id, own weight, capacity), always ready;
//    write only while no event is in flight
// timing
//  - an event passes an update step and an own-entry read, then a walk of
//    one table entry per cycle through the single read port of the table
//    memory, then a drain step, before its result is valid
//  - one event at a time: a new transaction is taken only once the result
//    of the previous one has been loaded
//  - req_stall is high from acceptance until the result is loaded
//  - the result register decouples the receiver: while rsp_stall holds a
//    result, the next event is accepted and walked, and waits only to load
// reset
//  - synchronous: clock to zero, all table entries invalid, registers to
//    own id 0, own weight 1, capacity 255; no clearing pass is needed
module lamport_weighted_admission_queue #(
   parameter int MAX_NODES = lwaq_pkg::DEFAULT_MAX_NODES
) (
   input  logic                                clock,
   input  logic                                reset,
   // event channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lwaq_pkg::ACT_W-1:0]          req_action,
   input  logic [lwaq_pkg::ID_W-1:0]           req_node_id,
   input  logic [lwaq_pkg::CLK_W-1:0]          req_stamp,
   input  logic [lwaq_pkg::WT_W-1:0]           req_weight,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lwaq_pkg::CLK_W-1:0]          rsp_local_clock,
   output logic signed [lwaq_pkg::AVAIL_W-1:0] rsp_available,
   output logic                                rsp_may_enter,
   output logic                                rsp_own_pending,
   output logic                                rsp_send_reply,
   output logic                                rsp_broadcast,
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lwaq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lwaq_pkg::CSR_DATA_W-1:0]     csr_data
);

   lwaq_pkg::cmd_type cmd;
   lwaq_pkg::sts_type sts;

   // registers are plain flops, a write never waits
   assign csr_ready = 1'b1;

   // sequencer: capture, update, own read, table walk, drain, result load
   lwaq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // clock, table memory, accumulation of weights ahead of own entry
   lwaq_dp #(
      .MAX_NODES (MAX_NODES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_action      (req_action),
      .req_node_id     (req_node_id),
      .req_stamp       (req_stamp),
      .req_weight      (req_weight),
      .csr_wr          (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_local_clock (rsp_local_clock),
      .rsp_available   (rsp_available),
      .rsp_may_enter   (rsp_may_enter),
      .rsp_own_pending (rsp_own_pending),
      .rsp_send_reply  (rsp_send_reply),
      .rsp_broadcast   (rsp_broadcast)
   );

   // an accepted transaction blocks the next one from the following cycle on
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("event channel not blocked after acceptance");

   // at most one command per cycle
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.update, cmd.rd_own, cmd.walk_step, cmd.out_load}))
      else $error("overlapping datapath commands");

   // a result never overwrites one that is still held by the receiver
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("result register overwritten while stalled");

   // the table update follows the capture directly
   a_update_follows_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.update)
      else $error("update missing after capture");

endmodule

// ===== bench/testbench.sv =====
// testbench: self-checking bench for lamport_weighted_admission_queue
// depends on lwaq_pkg and the rtl of the block; predicts every result with its
// own model of the logical clock and request table and checks it field by field
module testbench;

   localparam int NODES       = lwaq_pkg::DEFAULT_MAX_NODES;
   localparam int DRAIN       = NODES + 8;     // latency of one event plus margin
   localparam int CYCLE_LIMIT = 600000;
   localparam int SHOW_LIMIT  = 10;

   // one expected or observed result transaction
   typedef struct packed {
      logic [lwaq_pkg::CLK_W-1:0]          clk;
      logic signed [lwaq_pkg::AVAIL_W-1:0] avail;
      logic                                may_enter;
      logic                                own_pending;
      logic                                send_reply;
      logic                                broadcast;
   } admission_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic [lwaq_pkg::ACT_W-1:0]      req_action;
   logic [lwaq_pkg::ID_W-1:0]       req_node_id;
   logic [lwaq_pkg::CLK_W-1:0]      req_stamp;
   logic [lwaq_pkg::WT_W-1:0]       req_weight;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic [lwaq_pkg::CLK_W-1:0]      rsp_local_clock;
   logic signed [lwaq_pkg::AVAIL_W-1:0] rsp_available;
   logic                            rsp_may_enter;
   logic                            rsp_own_pending;
   logic                            rsp_send_reply;
   logic                            rsp_broadcast;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [lwaq_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [lwaq_pkg::CSR_DATA_W-1:0] csr_data;

   // shadow of the block: clock, request table and registers
   logic [lwaq_pkg::CLK_W-1:0] lamport_clock;
   logic                       slot_valid  [NODES];
   logic [lwaq_pkg::CLK_W-1:0] slot_stamp  [NODES];
   logic [lwaq_pkg::WT_W-1:0]  slot_weight [NODES];
   logic [lwaq_pkg::ID_W-1:0]  cfg_own_id;
   logic [lwaq_pkg::WT_W-1:0]  cfg_own_weight;
   logic [lwaq_pkg::CAP_W-1:0] cfg_capacity;

   admission_type admission_q[$];    // results still owed by the block
   admission_type got_result;
   admission_type want_result;

   int  mismatch_count;
   int  cycle_count;
   int  hold_request;              // receiver hold-off asked by a test, in cycles
   int  hold_left;
   bit  no_idle;                   // both sides run flat out while set

   lamport_weighted_admission_queue u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_node_id     (req_node_id),
      .req_stamp       (req_stamp),
      .req_weight      (req_weight),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_local_clock (rsp_local_clock),
      .rsp_available   (rsp_available),
      .rsp_may_enter   (rsp_may_enter),
      .rsp_own_pending (rsp_own_pending),
      .rsp_send_reply  (rsp_send_reply),
      .rsp_broadcast   (rsp_broadcast),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // 20 unit period, high then low
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver: random stalls, or a long hold-off when a test asks for one
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else begin
         rsp_stall = !no_idle && ($urandom_range(99) < 13);
      end
   end

   // saturating clock increment
   function automatic logic [lwaq_pkg::CLK_W-1:0] next_tick(
         input logic [lwaq_pkg::CLK_W-1:0] c);
      return (c == {lwaq_pkg::CLK_W{1'b1}}) ? c : c + 1'b1;
   endfunction

   // apply one event to the shadow state and return the result it should give
   function automatic admission_type predict_event(
         input lwaq_pkg::action_type act,
         input logic [lwaq_pkg::ID_W-1:0] node,
         input logic [lwaq_pkg::CLK_W-1:0] stamp,
         input logic [lwaq_pkg::WT_W-1:0] wt);
      admission_type r;
      int            acc;
      logic          pend;
      logic          ahead;
      r = '0;
      case (act)
         lwaq_pkg::ACT_REMOTE_REQ: begin
            lamport_clock = next_tick((stamp > lamport_clock) ? stamp : lamport_clock);
            // a remote event never touches the own slot
            if (node != cfg_own_id) begin
               slot_valid[node]  = 1'b1;
               slot_stamp[node]  = stamp;
               slot_weight[node] = wt;
            end
            r.send_reply = 1'b1;
         end
         lwaq_pkg::ACT_REMOTE_REL: begin
            lamport_clock = next_tick(lamport_clock);
            if (node != cfg_own_id) begin
               slot_valid[node]  = 1'b0;
               slot_stamp[node]  = '0;
               slot_weight[node] = '0;
            end
         end
         lwaq_pkg::ACT_LOCAL_REQ: begin
            lamport_clock = next_tick(lamport_clock);
            slot_valid[cfg_own_id]  = 1'b1;
            slot_stamp[cfg_own_id]  = lamport_clock;
            slot_weight[cfg_own_id] = cfg_own_weight;
            r.broadcast = 1'b1;
         end
         default: begin
            // local release leaves the clock alone
            slot_valid[cfg_own_id]  = 1'b0;
            slot_stamp[cfg_own_id]  = '0;
            slot_weight[cfg_own_id] = '0;
         end
      endcase
      pend = slot_valid[cfg_own_id];
      acc  = int'(cfg_capacity);
      // entries ahead of the own one by (stamp, id); all of them if none pending
      for (int i = 0; i < NODES; i++) begin
         if (slot_valid[i] && !(pend && i == cfg_own_id)) begin
            ahead = !pend || (slot_stamp[i] < slot_stamp[cfg_own_id]) ||
                    (slot_stamp[i] == slot_stamp[cfg_own_id] && i < cfg_own_id);
            if (ahead)
               acc -= int'(slot_weight[i]);
         end
      end
      r.clk         = lamport_clock;
      r.avail       = acc[lwaq_pkg::AVAIL_W-1:0];
      r.own_pending = pend;
      r.may_enter   = pend && (int'(cfg_own_weight) <= acc);
      return r;
   endfunction

   // result checker, oldest expectation first
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_result.clk         = rsp_local_clock;
         got_result.avail       = rsp_available;
         got_result.may_enter   = rsp_may_enter;
         got_result.own_pending = rsp_own_pending;
         got_result.send_reply  = rsp_send_reply;
         got_result.broadcast   = rsp_broadcast;
         if (admission_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= SHOW_LIMIT)
               $display("cycle %0d: result with nothing expected: clock=%h avail=%0d",
                        cycle_count, got_result.clk, got_result.avail);
         end else begin
            want_result = admission_q.pop_front();
            if (got_result.clk !== want_result.clk ||
                got_result.avail !== want_result.avail ||
                got_result.may_enter !== want_result.may_enter ||
                got_result.own_pending !== want_result.own_pending ||
                got_result.send_reply !== want_result.send_reply ||
                got_result.broadcast !== want_result.broadcast) begin
               mismatch_count++;
               if (mismatch_count <= SHOW_LIMIT) begin
                  $display("cycle %0d: mismatch", cycle_count);
                  $display("  expected clock=%h avail=%0d enter=%b pend=%b reply=%b bcast=%b",
                           want_result.clk, want_result.avail, want_result.may_enter,
                           want_result.own_pending, want_result.send_reply,
                           want_result.broadcast);
                  $display("  actual   clock=%h avail=%0d enter=%b pend=%b reply=%b bcast=%b",
                           got_result.clk, got_result.avail, got_result.may_enter,
                           got_result.own_pending, got_result.send_reply,
                           got_result.broadcast);
               end
            end
         end
      end
   end

   // offer one event transaction; valid stays high afterwards so back-to-back
   // transactions need no low cycle, the next call or settle moves it on
   task automatic send_event(input lwaq_pkg::action_type act,
                             input logic [lwaq_pkg::ID_W-1:0] node,
                             input logic [lwaq_pkg::CLK_W-1:0] stamp,
                             input logic [lwaq_pkg::WT_W-1:0] wt);
      @(negedge clock);
      if (!no_idle && $urandom_range(99) < 13) begin
         req_valid = 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_action  = act;
      req_node_id = node;
      req_stamp   = stamp;
      req_weight  = wt;
      do @(posedge clock); while (req_stall);
      admission_q.push_back(predict_event(act, node, stamp, wt));
   endtask

   // stop offering and wait until every result is in and the block is quiet
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (admission_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_reg(input lwaq_pkg::csr_index_type idx,
                            input logic [lwaq_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         lwaq_pkg::CSR_OWN_ID:     cfg_own_id     = value[lwaq_pkg::ID_W-1:0];
         lwaq_pkg::CSR_OWN_WEIGHT: cfg_own_weight = value[lwaq_pkg::WT_W-1:0];
         lwaq_pkg::CSR_CAPACITY:   cfg_capacity   = value[lwaq_pkg::CAP_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_config(input logic [lwaq_pkg::ID_W-1:0] id,
                             input logic [lwaq_pkg::WT_W-1:0] wt,
                             input logic [lwaq_pkg::CAP_W-1:0] cap);
      settle();
      write_reg(lwaq_pkg::CSR_OWN_ID, lwaq_pkg::CSR_DATA_W'(id));
      write_reg(lwaq_pkg::CSR_OWN_WEIGHT, lwaq_pkg::CSR_DATA_W'(wt));
      write_reg(lwaq_pkg::CSR_CAPACITY, cap);
   endtask

   // events on an empty table and remote events that name the own node
   task automatic test_empty_and_own_id();
      send_event(lwaq_pkg::ACT_LOCAL_REL, 4'd0, 32'd0, 8'd0);
      send_event(lwaq_pkg::ACT_REMOTE_REL, 4'd7, 32'd0, 8'd0);
      send_event(lwaq_pkg::ACT_REMOTE_REQ, 4'd0, 32'd3, 8'd50);
      send_event(lwaq_pkg::ACT_REMOTE_REL, 4'd0, 32'd0, 8'd0);
      send_event(lwaq_pkg::ACT_REMOTE_REQ, 4'd6, 32'd0, 8'd0);
   endtask

   // queue order by stamp then id, repeated requests, own id moved while pending
   task automatic test_ordering();
      logic [lwaq_pkg::CLK_W-1:0] own_stamp;
      set_config(4'd5, 8'd20, 16'd100);
      write_reg(lwaq_pkg::CSR_UNUSED, 16'hFFFF);
      send_event(lwaq_pkg::ACT_REMOTE_REQ, 4'd2, lamport_clock, 8'd30);
      send_event(lwaq_pkg::ACT_LOCAL_REQ, 4'd0, 32'd0, 8'd0);
      own_stamp = lamport_clock;
      send_event(lwaq_pkg::ACT_REMOTE_REQ, 4'd3, own_stamp, 8'd40);     // tie, lower id ahead
      send_event(lwaq_pkg::ACT_REMOTE_REQ, 4'd9, own_stamp, 8'd50);     // tie, higher id behind
      send_event(lwaq_pkg::ACT_REMOTE_REQ, 4'd4, own_stamp + 1, 8'd60); // later stamp behind
      send_event(lwaq_pkg::ACT_LOCAL_REQ, 4'd0, 32'd0, 8'd0);           // re-request, new stamp
      send_event(lwaq_pkg::ACT_REMOTE_REQ, 4'd2, 32'd0, 8'd255);        // overwrite node 2
      send_event(lwaq_pkg::ACT_REMOTE_REL, 4'd3, 32'd0, 8'd0);
      send_event(lwaq_pkg::ACT_LOCAL_REL, 4'd0, 32'd0, 8'd0);
      send_event(lwaq_pkg::ACT_REMOTE_REL, 4'd15, 32'd0, 8'd0);
      send_event(lwaq_pkg::ACT_LOCAL_REQ, 4'd0, 32'd0, 8'd0);
      // slot 9 holds a remote entry; it becomes the own entry
      set_config(4'd9, 8'd255, 16'd65535);
      send_event(lwaq_pkg::ACT_REMOTE_REL, 4'd4, 32'd0, 8'd0);
      send_event(lwaq_pkg::ACT_REMOTE_REQ, 4'd9, 32'd1, 8'd1);          // own slot left alone
   endtask

   // mostly request/release pairs with stamps near the clock, plus noise
   task automatic test_random_traffic(input int count, input bit light_weights);
      lwaq_pkg::action_type       act;
      logic [lwaq_pkg::ID_W-1:0]  node;
      logic [lwaq_pkg::CLK_W-1:0] stamp;
      logic [lwaq_pkg::WT_W-1:0]  wt;
      longint                     near;
      int                         pick;
      int                         j;
      bit                         found;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 40)      act = lwaq_pkg::ACT_REMOTE_REQ;
         else if (pick < 62) act = lwaq_pkg::ACT_REMOTE_REL;
         else if (pick < 82) act = lwaq_pkg::ACT_LOCAL_REQ;
         else                act = lwaq_pkg::ACT_LOCAL_REL;
         node = lwaq_pkg::ID_W'($urandom_range(NODES - 1));
         // releases usually name a node that really has an entry
         if (act == lwaq_pkg::ACT_REMOTE_REL && $urandom_range(3) != 0) begin
            found = 1'b0;
            for (int k = 0; k < NODES; k++) begin
               j = (int'(node) + k) % NODES;
               if (!found && slot_valid[j] && j != cfg_own_id) begin
                  node  = lwaq_pkg::ID_W'(j);
                  found = 1'b1;
               end
            end
         end
         pick = $urandom_range(99);
         if (pick < 3) begin
            stamp = $urandom;
         end else if (pick < 8) begin
            stamp = $urandom_range(255);
         end else begin
            near = longint'(lamport_clock) + $urandom_range(8) - 4;
            if (near < 0) near = 0;
            if (near > 64'hFFFF_FFFF) near = 64'hFFFF_FFFF;
            stamp = near[lwaq_pkg::CLK_W-1:0];
         end
         if (light_weights)
            wt = ($urandom_range(19) == 0) ? 8'd255 : 8'($urandom_range(15));
         else
            wt = lwaq_pkg::WT_W'($urandom_range(255));
         send_event(act, node, stamp, wt);
      end
   endtask

   // receiver holds off while events keep coming, so the input stalls
   task automatic test_backpressure();
      settle();
      hold_request = 300;
      test_random_traffic(12, 1'b1);
   endtask

   // clock pinned at its maximum; runs last since only reset brings it back
   task automatic test_clock_saturation();
      send_event(lwaq_pkg::ACT_REMOTE_REQ, 4'd1, 32'hFFFF_FFFF, 8'd255);
      send_event(lwaq_pkg::ACT_REMOTE_REL, 4'd1, 32'd0, 8'd0);
      send_event(lwaq_pkg::ACT_LOCAL_REQ, 4'd0, 32'd0, 8'd0);
      send_event(lwaq_pkg::ACT_REMOTE_REQ, 4'd2, 32'hFFFF_FFFE, 8'd7);
      send_event(lwaq_pkg::ACT_LOCAL_REL, 4'd0, 32'd0, 8'd0);
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_action     = lwaq_pkg::ACT_REMOTE_REQ;
      req_node_id    = '0;
      req_stamp      = '0;
      req_weight     = '0;
      rsp_stall      = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = lwaq_pkg::CSR_OWN_ID;
      csr_data       = '0;
      mismatch_count = 0;
      cycle_count    = 0;
      hold_request   = 0;
      hold_left      = 0;
      no_idle        = 1'b0;
      lamport_clock  = '0;
      cfg_own_id     = lwaq_pkg::OWN_ID_RESET;
      cfg_own_weight = lwaq_pkg::OWN_WEIGHT_RESET;
      cfg_capacity   = lwaq_pkg::CAPACITY_RESET;
      for (int i = 0; i < NODES; i++) begin
         slot_valid[i]  = 1'b0;
         slot_stamp[i]  = '0;
         slot_weight[i] = '0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_and_own_id();
      test_ordering();

      set_config(4'd4, 8'd10, 16'd100);
      test_random_traffic(320, 1'b1);

      // long stretch with no idling on either side, extremes high
      set_config(4'd15, 8'd255, 16'd65535);
      no_idle = 1'b1;
      test_random_traffic(320, 1'b0);
      settle();
      no_idle = 1'b0;

      set_config(4'd0, 8'd0, 16'd0);
      test_random_traffic(320, 1'b1);

      set_config(lwaq_pkg::ID_W'($urandom_range(15)), lwaq_pkg::WT_W'($urandom_range(255)),
                 lwaq_pkg::CAP_W'($urandom_range(65535)));
      test_random_traffic(320, 1'b0);

      test_backpressure();

      set_config(4'd9, 8'd40, 16'd300);
      test_random_traffic(320, 1'b1);

      set_config(lwaq_pkg::ID_W'($urandom_range(15)), lwaq_pkg::WT_W'($urandom_range(63)),
                 lwaq_pkg::CAP_W'($urandom_range(600)));
      test_random_traffic(300, 1'b1);

      test_clock_saturation();
      settle();

      // anything still owed counts as missing
      mismatch_count += admission_q.size();
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/lwaq_pkg.sv
hw/rtl/lwaq_ctrl.sv
hw/rtl/lwaq_dp.sv
hw/rtl/lamport_weighted_admission_queue.sv
bench/testbench.sv
